// ----- hdl/sva_pkg.sv -----
package sva_pkg;

	localparam int NUM_VOICES_DEF = 24;

	localparam int PRI_W = 15;
	localparam int VOICE_W = 5;

	localparam logic [PRI_W-1:0] PRI_CEILING = 15'h7FFF;

	localparam logic [1:0] ST_FREE = 2'd0;
	localparam logic [1:0] ST_SUSTAIN = 2'd1;
	localparam logic [1:0] ST_RELEASE = 2'd2;

	localparam logic [1:0] SRC_FREE = 2'd0;
	localparam logic [1:0] SRC_REL = 2'd1;
	localparam logic [1:0] SRC_SUS = 2'd2;
	localparam logic [1:0] SRC_NONE = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_SET = 1'b1;

	typedef struct packed {
		logic [1:0]       status;
		logic [PRI_W-1:0] pri;
		logic             locked;
		logic             claimed;
	} entry_t;

	// per-cell update controls, applied only while the ring is at rest
	typedef struct packed {
		logic set;
		logic make_sus;
		logic claim;
	} upd_t;

endpackage

// ----- hdl/sva_cell.sv -----
module sva_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  sva_pkg::entry_t nbr,
	input  sva_pkg::upd_t   upd,
	input  sva_pkg::entry_t set_data,
	output sva_pkg::entry_t entry
);

	sva_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= nbr;
		end else if (upd.set) begin
			entry_q.status  <= set_data.status;
			entry_q.pri     <= set_data.pri;
			entry_q.locked  <= set_data.locked;
			entry_q.claimed <= 1'b0;
		end else begin
			if (upd.make_sus)
				entry_q.status <= sva_pkg::ST_SUSTAIN;
			if (upd.claim)
				entry_q.claimed <= 1'b1;
		end
	end

	assign entry = entry_q;

endmodule

// ----- hdl/sva_scan.sv -----
module sva_scan #(
	parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          step,
	input  sva_pkg::entry_t               head,
	input  logic [$clog2(NUM_VOICES)-1:0] head_idx,
	input  logic [sva_pkg::PRI_W-1:0]     req_pri,
	output logic                          free_found,
	output logic [$clog2(NUM_VOICES)-1:0] free_idx,
	output logic                          rel_ok,
	output logic [$clog2(NUM_VOICES)-1:0] rel_idx,
	output logic                          sus_ok,
	output logic [$clog2(NUM_VOICES)-1:0] sus_idx
);

	localparam int IDX_W = $clog2(NUM_VOICES);

	logic                      free_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic [sva_pkg::PRI_W-1:0] rel_pri_q;
	logic [IDX_W-1:0]          rel_idx_q;
	logic [sva_pkg::PRI_W-1:0] sus_pri_q;
	logic [IDX_W-1:0]          sus_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q     <= 1'b0;
			free_idx_q <= '0;
			rel_pri_q  <= sva_pkg::PRI_CEILING;
			rel_idx_q  <= '0;
			sus_pri_q  <= sva_pkg::PRI_CEILING;
			sus_idx_q  <= '0;
		end else if (clear) begin
			free_q    <= 1'b0;
			rel_pri_q <= sva_pkg::PRI_CEILING;
			sus_pri_q <= sva_pkg::PRI_CEILING;
		end else if (step && !free_q && !head.locked) begin
			if (head.status == sva_pkg::ST_FREE) begin
				free_q     <= 1'b1;
				free_idx_q <= head_idx;
			end else if (head.status == sva_pkg::ST_RELEASE) begin
				if (head.pri < rel_pri_q) begin
					rel_pri_q <= head.pri;
					rel_idx_q <= head_idx;
				end
			end else if (head.pri < sus_pri_q) begin
				// status three falls in here with the sustaining voices
				sus_pri_q <= head.pri;
				sus_idx_q <= head_idx;
			end
		end
	end

	// a best priority below the ceiling means a candidate was seen
	assign free_found = free_q;
	assign free_idx   = free_idx_q;
	assign rel_ok     = (rel_pri_q != sva_pkg::PRI_CEILING) && (req_pri >= rel_pri_q);
	assign rel_idx    = rel_idx_q;
	assign sus_ok     = (sus_pri_q != sva_pkg::PRI_CEILING) && (req_pri >= sus_pri_q);
	assign sus_idx    = sus_idx_q;

endmodule

// ----- hdl/synth_voice_allocator.sv -----
// Allocate request: the voice entries rotate once around a ring of cells past a single compare
// unit, then a decide state follows, and the result strobes after it.
// Set request: written at the accepting edge, result strobes in the next cycle; one per cycle
// while not busy. busy is high during the scan and decide cycles only; the next request may be
// accepted in the cycle that carries the strobe. The receiver cannot stall.
// Reset (arst_n low) clears every voice entry to free, priority zero, unlocked, unclaimed.
module synth_voice_allocator #(
	parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [sva_pkg::PRI_W-1:0]     request_priority,
	input  logic [sva_pkg::VOICE_W-1:0]   target_voice,
	input  logic [1:0]                    new_status,
	input  logic [sva_pkg::PRI_W-1:0]     new_priority,
	input  logic                          new_locked,
	output logic                          done,
	output logic                          granted,
	output logic [sva_pkg::VOICE_W-1:0]   granted_voice,
	output logic [1:0]                    grant_source
);

	localparam int IDX_W = $clog2(NUM_VOICES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

	typedef enum logic [1:0] {IDLE, SCAN, DECIDE} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          cnt_q;
	logic [sva_pkg::PRI_W-1:0] req_pri_q;
	logic                      done_q;
	logic                      granted_q;
	logic [IDX_W-1:0]          voice_q;
	logic [1:0]                src_q;

	logic accept, alloc_go, set_go, set_in_range;

	sva_pkg::entry_t entries [NUM_VOICES];
	sva_pkg::upd_t   upd     [NUM_VOICES];
	sva_pkg::entry_t set_data;

	logic             free_found, rel_ok, sus_ok;
	logic [IDX_W-1:0] free_idx, rel_idx, sus_idx;

	logic             dec_hit;
	logic             dec_sus;
	logic [IDX_W-1:0] dec_idx;
	logic [1:0]       dec_src;

	assign accept       = start && !busy;
	assign alloc_go     = accept && (req_type == sva_pkg::REQ_ALLOC);
	assign set_go       = accept && (req_type == sva_pkg::REQ_SET);
	assign set_in_range = 32'(target_voice) < NUM_VOICES;
	assign busy         = (state_q != IDLE);

	assign set_data.status  = new_status;
	assign set_data.pri     = new_priority;
	assign set_data.locked  = new_locked;
	assign set_data.claimed = 1'b0;

	always_comb begin
		dec_hit = 1'b1;
		dec_sus = 1'b0;
		dec_idx = '0;
		dec_src = sva_pkg::SRC_NONE;
		priority if (free_found) begin
			dec_sus = 1'b1;
			dec_idx = free_idx;
			dec_src = sva_pkg::SRC_FREE;
		end else if (rel_ok) begin
			dec_idx = rel_idx;
			dec_src = sva_pkg::SRC_REL;
		end else if (sus_ok) begin
			dec_idx = sus_idx;
			dec_src = sva_pkg::SRC_SUS;
		end else begin
			dec_hit = 1'b0;
		end
	end

	// ring: cell k takes from cell k+1, cell 0 is the head seen by the scanner
	for (genvar k = 0; k < NUM_VOICES; k++) begin : g_cell
		logic dec_here;
		assign dec_here        = (state_q == DECIDE) && dec_hit && (dec_idx == IDX_W'(k));
		assign upd[k].set      = set_go && set_in_range && (32'(target_voice) == k);
		assign upd[k].make_sus = dec_here && dec_sus;
		assign upd[k].claim    = dec_here;

		sva_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (state_q == SCAN),
			.nbr      (entries[(k + 1) % NUM_VOICES]),
			.upd      (upd[k]),
			.set_data (set_data),
			.entry    (entries[k])
		);
	end

	sva_scan #(
		.NUM_VOICES (NUM_VOICES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (alloc_go),
		.step       (state_q == SCAN),
		.head       (entries[0]),
		.head_idx   (cnt_q),
		.req_pri    (req_pri_q),
		.free_found (free_found),
		.free_idx   (free_idx),
		.rel_ok     (rel_ok),
		.rel_idx    (rel_idx),
		.sus_ok     (sus_ok),
		.sus_idx    (sus_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			cnt_q     <= '0;
			req_pri_q <= '0;
			done_q    <= 1'b0;
			granted_q <= 1'b0;
			voice_q   <= '0;
			src_q     <= sva_pkg::SRC_NONE;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (alloc_go) begin
						state_q   <= SCAN;
						cnt_q     <= '0;
						req_pri_q <= request_priority;
					end else if (set_go) begin
						done_q    <= 1'b1;
						granted_q <= 1'b0;
						voice_q   <= '0;
						src_q     <= sva_pkg::SRC_NONE;
					end
				end
				SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX)
						state_q <= DECIDE;
				end
				DECIDE: begin
					state_q   <= IDLE;
					done_q    <= 1'b1;
					granted_q <= dec_hit;
					voice_q   <= dec_idx;
					src_q     <= dec_src;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign granted       = granted_q;
	assign granted_voice = sva_pkg::VOICE_W'(voice_q);
	assign grant_source  = src_q;

`ifndef NO_ASSERTIONS
	a_alloc_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_go |=> (state_q == SCAN) && (cnt_q == '0))
		else $error("allocate request did not start a scan");

	a_no_grant_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && !granted |-> (granted_voice == '0) && (grant_source == sva_pkg::SRC_NONE))
		else $error("no-grant result carries a voice or source");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && granted |-> (32'(voice_q) < NUM_VOICES) && (grant_source != sva_pkg::SRC_NONE))
		else $error("grant outside the voice range");

	a_decide_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DECIDE) |=> done && !busy)
		else $error("decide cycle did not produce a result");

	a_free_grant_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DECIDE) && free_found |=>
			entries[voice_q].claimed && (entries[voice_q].status == sva_pkg::ST_SUSTAIN))
		else $error("free voice grant not marked sustaining and claimed");
`endif

endmodule
